[hw/rtl/assert_macros.svh]
// Assertion macros used by the top-level RTL file of the allocator.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define ASSERT_SAME(lbl, clk, rst, a, c) \
  lbl: assert property (@(posedge clk) disable iff (rst) (a) |-> (c)) \
    else $error("assertion failed");

// The consequent must hold in the cycle after the antecedent.
`define ASSERT_NEXT(lbl, clk, rst, a, c) \
  lbl: assert property (@(posedge clk) disable iff (rst) (a) |=> (c)) \
    else $error("assertion failed");

`endif

[hw/rtl/scsa_pkg.sv]
// Package of types, codes and size-class tables for the slab allocator.
package scsa_pkg;

  localparam int unsigned NUM_CLASSES = 5;
  localparam int unsigned SLOT_BITS   = 15;

  typedef logic [2:0] class_t;
  typedef logic [3:0] slot_t;
  typedef logic [SLOT_BITS-1:0] bitmap_t;

  typedef enum logic [2:0] {
    ST_OK       = 3'd0,
    ST_ZERO     = 3'd1,
    ST_TOO_BIG  = 3'd2,
    ST_NO_PAGES = 3'd3,
    ST_NOT_OWN  = 3'd4
  } status_t;

  localparam logic REQ_ALLOC = 1'b0;
  localparam logic REQ_FREE  = 1'b1;

  // Size class of a request of 1..56 bytes.
  function automatic class_t size_class(input logic [15:0] size);
    class_t c;
    if (size <= 16'd8) c = 3'd0;
    else if (size <= 16'd16) c = 3'd1;
    else if (size <= 16'd24) c = 3'd2;
    else if (size <= 16'd40) c = 3'd3;
    else c = 3'd4;
    return c;
  endfunction

  // Valid slots of a page of each class.
  function automatic bitmap_t class_mask(input class_t c);
    bitmap_t m;
    case (c)
      3'd0:    m = 15'h7FFF;
      3'd1:    m = 15'h007F;
      3'd2:    m = 15'h001F;
      3'd3:    m = 15'h0007;
      default: m = 15'h0003;
    endcase
    return m;
  endfunction

  // Lowest clear bit of a bitmap that is known not to be full.
  function automatic slot_t first_zero(input bitmap_t bm);
    slot_t s;
    logic  hit;
    s   = '0;
    hit = 1'b0;
    for (int i = 0; i < SLOT_BITS; i++) begin
      if (!hit && !bm[i]) begin
        s   = slot_t'(i);
        hit = 1'b1;
      end
    end
    return s;
  endfunction

  // Byte offset of a slot within its page, header included.
  function automatic logic [6:0] slot_offset(input class_t c, input slot_t s);
    logic [6:0] o;
    case (c)
      3'd0:    o = 7'd8 + {s, 3'b000};
      3'd1:    o = 7'd8 + {s[2:0], 4'b0000};
      3'd2:    o = 7'd8 + {s[2:0], 4'b0000} + {1'b0, s[2:0], 3'b000};
      3'd3:    o = 7'd8 + {s[1:0], 5'b00000} + {1'b0, s[1:0], 3'b000};
      default: o = 7'd8 + {s[0], 6'b000000} - {3'b000, s[0], 3'b000};
    endcase
    return o;
  endfunction

  // Slot that a byte offset of 1..127 falls in; header bytes map to slot 0.
  // Division by the slot size is a multiply by a reciprocal on the offset in
  // units of eight bytes, exact over this short range.
  function automatic slot_t offset_slot(input class_t c, input logic [6:0] off);
    logic [6:0] v;
    logic [3:0] x;
    logic [9:0] prod;
    slot_t s;
    v    = off - 7'd8;
    x    = v[6:3];
    prod = '0;
    case (c)
      3'd0:    s = x;
      3'd1:    s = {1'b0, x[3:1]};
      3'd2: begin
        prod = 10'(x) * 10'd11;
        s    = slot_t'(prod[9:5]);
      end
      3'd3: begin
        prod = 10'(x) * 10'd13;
        s    = slot_t'(prod[9:6]);
      end
      default: begin
        prod = 10'(x) * 10'd37;
        s    = slot_t'(prod[9:8]);
      end
    endcase
    if (off < 7'd8) s = '0;
    return s;
  endfunction

endpackage

[hw/rtl/scsa_ram.sv]
// Generic single-port-write, single-port-read RAM with registered read data.
module scsa_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                                    clk,
  input  logic                                    wr_en,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
  input  logic [WIDTH-1:0]                        wr_data,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
  output logic [WIDTH-1:0]                        rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port and registered read port.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule

[hw/rtl/size_class_slab_allocator.sv]
// Top level of the size-class slab allocator with its request sequencer.
//
// Channel  Dir  Handshake            Payload
// s_       in   s_tvalid/s_tready    tdata: request_size, block_addr; tuser: req_type
// m_       out  m_tvalid/m_tready    tdata: result_addr, status, page_released
// cfg_     in   cfg_valid/cfg_ready  cfg_data: pool_base
//
// An allocation checks the size, then walks its class list until a page has room; at
// the end of the list it reuses a recycled page or opens a fresh one and pushes it onto
// the list. A bad size goes straight to the output. A free walks the class lists
// in turn to find the owning page, clears the slot, and releases the page to the recycled
// list once it is empty. The walk is bound by the registered read of the link and bitmap
// memories.
// Reset clears the list heads and the fresh-page count at once; no sweep.
// A new item is taken only when the previous one has reached the output
// register; the output register holds its item while m_tready is low.
`include "assert_macros.svh"

module size_class_slab_allocator #(
  parameter int NUM_PAGES = 64
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [47:0] s_tdata,   // request_size[15:0], block_addr[47:16]
  input  logic        s_tuser,   // req_type
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [39:0] m_tdata,   // result_addr[31:0], status[34:32],
                                 // page_released[35], zero fill[39:36]
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [31:0] cfg_data
);

  import scsa_pkg::*;

  localparam int PW = $clog2(NUM_PAGES + 1);
  localparam int AW = (NUM_PAGES > 1) ? $clog2(NUM_PAGES) : 1;
  localparam logic [PW-1:0] NIL = PW'(NUM_PAGES);

  typedef enum logic [3:0] {
    S_IDLE, S_A_CHK, S_A_RD, S_A_EV, S_A_NEW, S_A_REC, S_A_PUSH,
    S_F_CHK, S_F_RD, S_F_NX, S_F_BM, S_F_REL, S_FIN
  } state_t;

  state_t          state;
  logic [31:0]     pool_base;
  logic [PW-1:0]   class_head [NUM_CLASSES];
  logic [PW-1:0]   recycled_head;
  logic [PW-1:0]   pages_taken;
  logic [15:0]     request_size;
  logic [31:0]     block_addr;
  class_t          cls;
  logic [PW-1:0]   page;
  logic [PW-1:0]   prev;
  logic [31:0]     res_addr;
  status_t         res_status;
  logic            res_rel;

  logic            link_we, bm_we;
  logic [AW-1:0]   link_waddr, bm_waddr, rd_addr;
  logic [PW-1:0]   link_wdata, link_rdata;
  bitmap_t         bm_wdata, bm_rdata;

  logic [24:0]     page_hi;
  logic            owned;
  slot_t           alloc_slot, free_slot;
  bitmap_t         bm_cleared;

  // Shared page address adder: upper bits of the current page's address.
  assign page_hi    = pool_base[31:7] + 25'(page);
  assign owned      = (block_addr[31:7] == page_hi) && (block_addr[6:0] != 7'd0);
  assign alloc_slot = first_zero(bm_rdata);
  assign free_slot  = offset_slot(cls, block_addr[6:0]);
  assign bm_cleared = bm_rdata & ~(bitmap_t'(1) << free_slot);

  assign s_tready  = (state == S_IDLE);
  assign cfg_ready = 1'b1;

  scsa_ram #(.WIDTH(PW), .DEPTH(NUM_PAGES)) u_link (
    .clk(clk), .wr_en(link_we), .wr_addr(link_waddr), .wr_data(link_wdata),
    .rd_addr(rd_addr), .rd_data(link_rdata)
  );

  scsa_ram #(.WIDTH(SLOT_BITS), .DEPTH(NUM_PAGES)) u_bitmap (
    .clk(clk), .wr_en(bm_we), .wr_addr(bm_waddr), .wr_data(bm_wdata),
    .rd_addr(rd_addr), .rd_data(bm_rdata)
  );

  // Memory port control per sequencer state.
  always_comb begin
    link_we    = 1'b0;
    link_waddr = page[AW-1:0];
    link_wdata = class_head[cls];
    bm_we      = 1'b0;
    bm_waddr   = page[AW-1:0];
    bm_wdata   = bm_rdata | (bitmap_t'(1) << alloc_slot);
    rd_addr    = page[AW-1:0];
    unique case (state)
      S_A_NEW:  rd_addr = recycled_head[AW-1:0];
      S_A_EV:   bm_we = ((bm_rdata & class_mask(cls)) != class_mask(cls));
      S_A_PUSH: begin
        link_we  = 1'b1;
        bm_we    = 1'b1;
        bm_wdata = bitmap_t'(1);
      end
      S_F_BM: begin
        bm_we      = 1'b1;
        bm_wdata   = bm_cleared;
        link_we    = (bm_cleared == '0) && (prev != NIL);
        link_waddr = prev[AW-1:0];
        link_wdata = link_rdata;
      end
      S_F_REL: begin
        link_we    = 1'b1;
        link_wdata = recycled_head;
      end
      default: ;
    endcase
  end

  // Sequencer, list registers and output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_IDLE;
      pool_base     <= '0;
      recycled_head <= NIL;
      pages_taken   <= '0;
      m_tvalid      <= 1'b0;
      for (int i = 0; i < NUM_CLASSES; i++) begin
        class_head[i] <= NIL;
      end
    end else begin
      if (cfg_valid && cfg_ready) begin
        pool_base <= cfg_data;
      end
      if (m_tvalid && m_tready) begin
        m_tvalid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (s_tvalid) begin
            request_size <= s_tdata[15:0];
            block_addr   <= s_tdata[47:16];
            res_addr     <= '0;
            res_status   <= ST_OK;
            res_rel      <= 1'b0;
            state        <= (s_tuser == REQ_FREE) ? S_F_CHK : S_A_CHK;
          end
        end
        S_A_CHK: begin
          cls  <= size_class(request_size);
          page <= class_head[size_class(request_size)];
          if (request_size == 16'd0) begin
            res_status <= ST_ZERO;
            state      <= S_FIN;
          end else if (request_size > 16'd56) begin
            res_status <= ST_TOO_BIG;
            state      <= S_FIN;
          end else begin
            state <= S_A_RD;
          end
        end
        S_A_RD: begin
          state <= (page == NIL) ? S_A_NEW : S_A_EV;
        end
        S_A_EV: begin
          if ((bm_rdata & class_mask(cls)) != class_mask(cls)) begin
            res_addr <= {page_hi, slot_offset(cls, alloc_slot)};
            state    <= S_FIN;
          end else begin
            page  <= link_rdata;
            state <= S_A_RD;
          end
        end
        S_A_NEW: begin
          if (recycled_head != NIL) begin
            page  <= recycled_head;
            state <= S_A_REC;
          end else if (pages_taken != NIL) begin
            page        <= pages_taken;
            pages_taken <= pages_taken + PW'(1);
            state       <= S_A_PUSH;
          end else begin
            res_status <= ST_NO_PAGES;
            state      <= S_FIN;
          end
        end
        S_A_REC: begin
          recycled_head <= link_rdata;
          state         <= S_A_PUSH;
        end
        S_A_PUSH: begin
          class_head[cls] <= page;
          res_addr        <= {page_hi, slot_offset(cls, '0)};
          state           <= S_FIN;
        end
        S_F_CHK: begin
          cls   <= '0;
          page  <= class_head[0];
          prev  <= NIL;
          state <= (block_addr == '0) ? S_FIN : S_F_RD;
        end
        S_F_RD: begin
          if (page == NIL) begin
            if (cls == class_t'(NUM_CLASSES - 1)) begin
              res_status <= ST_NOT_OWN;
              state      <= S_FIN;
            end else begin
              cls  <= cls + 3'd1;
              page <= class_head[cls + 3'd1];
              prev <= NIL;
            end
          end else begin
            state <= owned ? S_F_BM : S_F_NX;
          end
        end
        S_F_NX: begin
          prev  <= page;
          page  <= link_rdata;
          state <= S_F_RD;
        end
        S_F_BM: begin
          if (bm_cleared == '0) begin
            if (prev == NIL) begin
              class_head[cls] <= link_rdata;
            end
            state <= S_F_REL;
          end else begin
            state <= S_FIN;
          end
        end
        S_F_REL: begin
          recycled_head <= page;
          res_rel       <= 1'b1;
          state         <= S_FIN;
        end
        S_FIN: begin
          if (!m_tvalid || m_tready) begin
            m_tvalid <= 1'b1;
            m_tdata  <= {4'b0000, res_rel, res_status, res_addr};
            state    <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // Fresh pages never exceed the pool.
  `ASSERT_SAME(a_pages_bound, clk, rst, 1'b1, pages_taken <= NIL)
  // A failed item never returns an address.
  `ASSERT_SAME(a_fail_zero, clk, rst, m_tvalid && (m_tdata[34:32] != ST_OK),
               m_tdata[31:0] == 32'd0)
  // A page is only released by a successful free.
  `ASSERT_SAME(a_rel_ok, clk, rst, m_tvalid && m_tdata[35],
               (m_tdata[34:32] == ST_OK) && (m_tdata[31:0] == 32'd0))
  // An accepted item keeps the input closed in the next cycle.
  `ASSERT_NEXT(a_one_item, clk, rst, s_tvalid && s_tready, !s_tready)

endmodule

[verif/size_class_slab_allocator_tb.sv]
// Self-checking testbench for the size-class slab allocator, with its own allocator predictor.
module size_class_slab_allocator_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import scsa_pkg::*;

  localparam int NPG      = 64;
  localparam int WD_LIMIT = 5000;

  // Expected result of one request.
  typedef struct packed {
    logic [31:0] addr;
    status_t     st;
    logic        rel;
  } alloc_res_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [47:0] s_tdata = '0;
  logic        s_tuser = 1'b0;
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [39:0] m_tdata;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [31:0] cfg_data = '0;

  size_class_slab_allocator #(.NUM_PAGES(NPG)) u_top (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data)
  );

  // Predictor state of the pool.
  logic [6:0]  pg_link  [NPG];
  bitmap_t     pg_bits  [NPG];
  logic [2:0]  pg_class [NPG];
  logic [6:0]  cls_head [NUM_CLASSES];
  logic [6:0]  recyc_head;
  int          fresh_taken;
  logic [31:0] pool_base_q;

  alloc_res_t  pending_q[$];
  logic [31:0] live_q[$];
  logic [31:0] freed_q[$];

  int err_cnt, n_items, n_alloc_ok, n_free, n_rel, n_nopg, n_notown, n_bad_size;
  int burst_left, hold_cnt, rx_mode, rx_left, idle_cnt;

  // Clock.
  initial begin
    forever #5 clk = ~clk;
  end

  function automatic int unsigned slot_bytes(int c);
    case (c)
      0: return 8;
      1: return 16;
      2: return 24;
      3: return 40;
      default: return 56;
    endcase
  endfunction

  function automatic logic [31:0] page_start(int p);
    return {pool_base_q[31:7], 7'b0} + 32'(p) * 32'd128;
  endfunction

  // Allocation: lowest free slot of the first non-full page, else a new page.
  function automatic alloc_res_t predict_alloc(logic [15:0] sz);
    alloc_res_t r;
    int c, p, steps, i;
    bitmap_t mask;
    r = '{addr: '0, st: ST_OK, rel: 1'b0};
    if (sz == 0) begin
      r.st = ST_ZERO;
      return r;
    end
    if (sz > 56) begin
      r.st = ST_TOO_BIG;
      return r;
    end
    c = 0;
    while (c < NUM_CLASSES - 1 && sz > slot_bytes(c)) c++;
    mask = bitmap_t'((1 << (120 / slot_bytes(c))) - 1);
    p = cls_head[c];
    steps = 0;
    while (p < NPG && steps < NPG) begin
      if ((pg_bits[p] & mask) != mask) break;
      p = pg_link[p];
      steps++;
    end
    if (p >= NPG || steps >= NPG) begin
      if (recyc_head < NPG) begin
        p = recyc_head;
        recyc_head = pg_link[p];
      end else if (fresh_taken < NPG) begin
        p = fresh_taken;
        fresh_taken++;
      end else begin
        r.st = ST_NO_PAGES;
        return r;
      end
      pg_class[p] = 3'(c);
      pg_bits[p]  = '0;
      pg_link[p]  = cls_head[c];
      cls_head[c] = 7'(p);
    end
    i = 0;
    while (i < 15 && pg_bits[p][i]) i++;
    pg_bits[p][i] = 1'b1;
    r.addr = page_start(p) + 32'd8 + 32'(slot_bytes(c) * i);
    return r;
  endfunction

  // Free: find the owning page, clear the slot, recycle the page if empty.
  function automatic alloc_res_t predict_free(logic [31:0] ad);
    alloc_res_t r;
    int c, p, q, prev, steps, slot;
    logic [31:0] off;
    logic found;
    r = '{addr: '0, st: ST_OK, rel: 1'b0};
    if (ad == 0) return r;
    found = 1'b0;
    p = NPG;
    off = '0;
    for (c = 0; c < NUM_CLASSES && !found; c++) begin
      p = cls_head[c];
      steps = 0;
      while (p < NPG && steps < NPG) begin
        off = ad - page_start(p);
        if (off >= 1 && off < 128) begin
          found = 1'b1;
          break;
        end
        p = pg_link[p];
        steps++;
      end
    end
    if (!found) begin
      r.st = ST_NOT_OWN;
      return r;
    end
    c = pg_class[p];
    if (c >= NUM_CLASSES) c = 0;
    slot = (off < 8) ? 0 : int'((off - 8) / slot_bytes(c));
    if (slot < 15) pg_bits[p][slot] = 1'b0;
    if (pg_bits[p] == '0) begin
      prev = NPG;
      q = cls_head[c];
      steps = 0;
      while (q < NPG && q != p && steps < NPG) begin
        prev = q;
        q = pg_link[q];
        steps++;
      end
      if (q == p) begin
        if (prev >= NPG) cls_head[c] = pg_link[p];
        else pg_link[prev] = pg_link[p];
      end
      pg_link[p]  = recyc_head;
      recyc_head  = 7'(p);
      pg_class[p] = 3'd7;
      r.rel = 1'b1;
    end
    return r;
  endfunction

  task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
    $display("MISMATCH %s: got %h expected %h at %0t", what, got, want, $realtime);
    err_cnt++;
  endtask

  // Send one item; the sender works in bursts with random gaps.
  task automatic send_req(logic rt, logic [15:0] sz, logic [31:0] ad);
    alloc_res_t r;
    int gap;
    if (burst_left <= 0) begin
      gap = $urandom_range(0, 6);
      if (gap > 0) begin
        s_tvalid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = ($urandom_range(0, 9) == 0) ? 40 : $urandom_range(1, 12);
    end
    r = (rt == REQ_ALLOC) ? predict_alloc(sz) : predict_free(ad);
    if (rt == REQ_ALLOC && r.st == ST_OK) live_q.push_back(r.addr);
    pending_q.push_back(r);
    s_tvalid <= 1'b1;
    s_tdata  <= {ad, sz};
    s_tuser  <= rt;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    burst_left--;
    n_items++;
  endtask

  task automatic free_addr(logic [31:0] ad);
    freed_q.push_back(ad);
    if (freed_q.size() > 16) void'(freed_q.pop_front());
    send_req(REQ_FREE, 16'($urandom()), ad);
  endtask

  task automatic free_live(int idx);
    logic [31:0] ad;
    ad = live_q[idx];
    live_q.delete(idx);
    free_addr(ad);
  endtask

  // Stop offering items and wait until every expected result has arrived.
  task automatic wait_drained();
    s_tvalid <= 1'b0;
    burst_left = 0;
    @(posedge clk);
    while (pending_q.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // Write pool_base while idle; live addresses move with the pool.
  task automatic write_pool_base(logic [31:0] v);
    wait_drained();
    foreach (live_q[k])
      live_q[k] = live_q[k] - {pool_base_q[31:7], 7'b0} + {v[31:7], 7'b0};
    freed_q.delete();
    cfg_valid <= 1'b1;
    cfg_data  <= v;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    pool_base_q = v;
  endtask

  // One random request: mostly well-formed allocations and frees of live blocks.
  task automatic random_req();
    int pick;
    logic [31:0] pg;
    pick = $urandom_range(0, 99);
    if (live_q.size() > 120 && pick < 60) pick = 60;
    if (pick < 50) begin
      send_req(REQ_ALLOC, 16'($urandom_range(1, 56)), $urandom());
    end else if (pick < 53) begin
      send_req(REQ_ALLOC, 16'd0, $urandom());
    end else if (pick < 56) begin
      send_req(REQ_ALLOC, 16'($urandom()) | 16'd64, $urandom());
    end else if (pick < 88 && live_q.size() > 0) begin
      free_live($urandom_range(0, live_q.size() - 1));
    end else if (pick < 92 && live_q.size() > 0) begin
      pg = live_q[$urandom_range(0, live_q.size() - 1)];
      free_addr({pg[31:7], 7'(pg[6:0] ^ 7'($urandom_range(1, 127)))});
    end else if (pick < 95 && freed_q.size() > 0) begin
      free_addr(freed_q[$urandom_range(0, freed_q.size() - 1)]);
    end else if (pick < 97) begin
      free_addr(32'd0);
    end else begin
      free_addr($urandom());
    end
  endtask

  // Extremes of the fields and the special cases of size and free address on a fresh pool.
  task automatic test_directed();
    logic [31:0] a56, pg;
    send_req(REQ_ALLOC, 16'd0, 32'hFFFF_FFFF);
    send_req(REQ_ALLOC, 16'hFFFF, 32'h0);
    send_req(REQ_ALLOC, 16'd57, 32'h0);
    send_req(REQ_ALLOC, 16'd56, 32'h0);
    a56 = live_q[$];
    foreach (live_q[k]) ;
    send_req(REQ_ALLOC, 16'd1, 32'h0);
    send_req(REQ_ALLOC, 16'd8, 32'h0);
    send_req(REQ_ALLOC, 16'd9, 32'h0);
    send_req(REQ_ALLOC, 16'd16, 32'h0);
    send_req(REQ_ALLOC, 16'd17, 32'h0);
    send_req(REQ_ALLOC, 16'd24, 32'h0);
    send_req(REQ_ALLOC, 16'd25, 32'h0);
    send_req(REQ_ALLOC, 16'd40, 32'h0);
    send_req(REQ_ALLOC, 16'd41, 32'h0);
    pg = {a56[31:7], 7'b0};
    // Frees of zero, a page start, past the last slot, the header, live and stray addresses.
    free_addr(32'd0);
    free_addr(pg);
    free_addr(pg + 32'd120);
    free_addr(pg + 32'd1);
    free_addr(pg + 32'd7);
    free_addr(pg + 32'd64);
    free_addr(32'hDEAD_BEEF);
    free_addr(pg + 32'd8);
    free_addr(pg + 32'd8);
    wait_drained();
  endtask

  // Fill the pool with two-slot pages until it runs out, then release them.
  task automatic test_exhaust();
    int k;
    for (k = 0; k < 2 * NPG + 8; k++) send_req(REQ_ALLOC, 16'($urandom_range(41, 56)), '0);
    for (k = live_q.size() - 1; k >= 0; k--) free_live(k);
    for (k = 0; k < 20; k++) send_req(REQ_ALLOC, 16'($urandom_range(1, 56)), '0);
  endtask

  // The receiver holds off for a long stretch while items keep coming.
  task automatic test_backpressure();
    hold_cnt = 400;
    repeat (30) random_req();
    wait_drained();
  endtask

  task automatic test_random(int count);
    repeat (count) random_req();
  endtask

  // Receiver stall pattern, a long hold-off, result checking and watchdog.
  always @(posedge clk) begin
    alloc_res_t want;
    logic any;
    if (hold_cnt > 0) begin
      m_tready <= 1'b0;
      hold_cnt <= hold_cnt - 1;
    end else begin
      if (rx_left <= 0) begin
        rx_mode <= $urandom_range(0, 2);
        rx_left <= $urandom_range(10, 80);
      end else begin
        rx_left <= rx_left - 1;
      end
      m_tready <= (rx_mode == 0) ? 1'b1 :
                  (rx_mode == 1) ? 1'($urandom()) : ($urandom_range(0, 7) != 0);
    end
    any = (s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready);
    if (!rst && m_tvalid && m_tready) begin
      if (pending_q.size() == 0) begin
        $display("MISMATCH unexpected result %h at %0t", m_tdata, $realtime);
        err_cnt++;
      end else begin
        want = pending_q.pop_front();
        if (m_tdata[31:0] != want.addr)
          report_mismatch("result_addr", m_tdata[31:0], want.addr);
        if (m_tdata[34:32] != want.st)
          report_mismatch("status", 32'(m_tdata[34:32]), 32'(want.st));
        if (m_tdata[35] != want.rel)
          report_mismatch("page_released", 32'(m_tdata[35]), 32'(want.rel));
        case (want.st)
          ST_OK:       if (want.addr != 0) n_alloc_ok++; else n_free++;
          ST_NO_PAGES: n_nopg++;
          ST_NOT_OWN:  n_notown++;
          default:     n_bad_size++;
        endcase
        if (want.rel) n_rel++;
      end
    end
    idle_cnt <= (any || rst) ? 0 : idle_cnt + 1;
    if (idle_cnt >= WD_LIMIT) begin
      $display("timeout: no handshake for %0d cycles", WD_LIMIT);
      $display("size_class_slab_allocator_tb: done, errors");
      $finish;
    end
  end

  // Test sequence.
  initial begin
    for (int p = 0; p < NPG; p++) begin
      pg_link[p]  = '0;
      pg_bits[p]  = '0;
      pg_class[p] = 3'd7;
    end
    for (int c = 0; c < NUM_CLASSES; c++) cls_head[c] = 7'(NPG);
    recyc_head = 7'(NPG);
    fresh_taken = 0;
    pool_base_q = '0;
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_directed();
    write_pool_base(32'hFFFF_FFFF);
    test_random(100);
    test_backpressure();
    test_exhaust();
    write_pool_base(32'h0000_0000);
    test_random(150);
    wait_drained();
    write_pool_base($urandom());
    test_random(150);
    write_pool_base(32'h8000_007F);
    test_random(100);
    wait_drained();
    repeat (200) @(posedge clk);
    $display("covered %0d items: %0d allocations, %0d frees, %0d pages released",
             n_items, n_alloc_ok, n_free, n_rel);
    $display("errors seen: %0d pool exhausted, %0d not owned, %0d bad sizes",
             n_nopg, n_notown, n_bad_size);
    if (err_cnt == 0) begin
      $display("size_class_slab_allocator_tb: done, clean");
    end else begin
      $display("size_class_slab_allocator_tb: done, errors");
    end
    $finish;
  end

endmodule

[sim.f]
+incdir+hw/rtl
hw/rtl/scsa_pkg.sv
hw/rtl/scsa_ram.sv
hw/rtl/size_class_slab_allocator.sv
verif/size_class_slab_allocator_tb.sv
